// ===== rtl/core/hht_pkg.sv =====
package hht_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;

  localparam logic [2:0] KIND_BLANK  = 3'd0;
  localparam logic [2:0] KIND_CRLF   = 3'd1;
  localparam logic [2:0] KIND_COLON  = 3'd2;
  localparam logic [2:0] KIND_COMMA  = 3'd3;
  localparam logic [2:0] KIND_STRING = 3'd4;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_ILLEGAL = 2'd1;
  localparam logic [1:0] ERR_UNTERM  = 2'd2;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_DQ   = 3'd1,
    MODE_SQ   = 3'd2,
    MODE_UNQ  = 3'd3,
    MODE_CR   = 3'd4,
    MODE_DROP = 3'd5
  } mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] token_kind;
    logic       token_start;
    logic       token_end;
    logic [1:0] error_code;
    logic       text_done;
    logic       last_result;
  } res_t;

  function automatic logic is_blank(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0B || b == 8'h0C;
  endfunction

  function automatic logic is_run_byte(input logic [7:0] b);
    return b >= 8'h21 && b <= 8'h7E && b != CH_COLON && b != CH_COMMA;
  endfunction

endpackage

// ===== rtl/core/http_header_tokenizer_top.sv =====
// path: a request passes the input register, then the lexer into the output queue,
// before its result leaves; a byte waits for its successor
// throughput: one request per cycle while the output side drains, up to two
// results per request, limited by one result read from the output queue per cycle
// reset: synchronous, clears lexer mode, held byte and queue pointers
module http_header_tokenizer_top import hht_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,  // data_byte
  input  logic       s_tlast,  // end_of_text
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,  // out_byte
  output logic [7:0] m_tuser,  // token_kind[2:0], token_start, token_end,
                               // error_code[1:0], last_result
  output logic       m_tlast   // text_done
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eot;
  logic       go;
  logic       room;
  res_t [1:0] res;
  logic [1:0] res_cnt;
  logic [1:0] push_cnt;
  res_t       head;

  assign go       = in_valid && room;
  assign s_tready = !in_valid || go;
  assign push_cnt = go ? res_cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_eot  <= s_tlast;
    end
  end

  hht_lexer u_lexer (
    .clk        (clk),
    .rst        (rst),
    .go         (go),
    .data_byte  (in_byte),
    .end_of_text(in_eot),
    .res        (res),
    .res_cnt    (res_cnt)
  );

  hht_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .wr_res  (res),
    .wr_cnt  (push_cnt),
    .room    (room),
    .rd_res  (head),
    .rd_valid(m_tvalid),
    .rd_ready(m_tready)
  );

  assign m_tdata = head.out_byte;
  assign m_tuser = {head.last_result, head.error_code, head.token_end,
                    head.token_start, head.token_kind};
  assign m_tlast = head.text_done;

endmodule

// ===== rtl/core/hht_lexer.sv =====
module hht_lexer import hht_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  logic [7:0] data_byte,
  input  logic       end_of_text,
  output res_t [1:0] res,
  output logic [1:0] res_cnt
);

  mode_t      mode, mode_next;
  logic [7:0] held_byte, held_byte_next;
  logic       held_valid, held_valid_next;
  logic [2:0] held_kind, held_kind_next;
  logic       held_start, held_start_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      held_byte  <= '0;
      held_valid <= 1'b0;
      held_kind  <= '0;
      held_start <= 1'b0;
    end else if (go) begin
      mode       <= mode_next;
      held_byte  <= held_byte_next;
      held_valid <= held_valid_next;
      held_kind  <= held_kind_next;
      held_start <= held_start_next;
    end
  end

  always_comb begin
    logic [7:0] b;
    logic       eot;
    logic [1:0] n;
    logic [2:0] kind;
    logic       st;
    logic       en;
    logic       ok;
    mode_t      nmode;
    b               = data_byte;
    eot             = end_of_text;
    n               = 2'd0;
    kind            = KIND_BLANK;
    st              = 1'b0;
    en              = 1'b0;
    ok              = 1'b1;
    nmode           = MODE_IDLE;
    res             = '0;
    mode_next       = mode;
    held_byte_next  = held_byte;
    held_valid_next = held_valid;
    held_kind_next  = held_kind;
    held_start_next = held_start;
    case (mode)
      MODE_DROP: begin
        if (eot) begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_CR: begin
        if (b != CH_LF) begin
          res[0]          = '{held_byte, KIND_BLANK, 1'b0, 1'b0, ERR_ILLEGAL, 1'b1, 1'b0};
          n               = 2'd1;
          held_valid_next = 1'b0;
          mode_next       = eot ? MODE_IDLE : MODE_DROP;
        end else begin
          res[0] = '{held_byte, KIND_CRLF, 1'b1, 1'b0, ERR_NONE, 1'b0, 1'b0};
          n      = 2'd1;
          if (eot) begin
            res[1]          = '{b, KIND_CRLF, 1'b0, 1'b1, ERR_NONE, 1'b1, 1'b0};
            n               = 2'd2;
            held_valid_next = 1'b0;
          end else begin
            held_byte_next  = b;
            held_kind_next  = KIND_CRLF;
            held_start_next = 1'b0;
            held_valid_next = 1'b1;
          end
          mode_next = MODE_IDLE;
        end
      end
      default: begin
        if (held_valid) begin
          if (mode == MODE_UNQ) begin
            en = !is_run_byte(b);
          end else begin
            en = held_kind != KIND_BLANK && mode == MODE_IDLE;
          end
          res[0]          = '{held_byte, held_kind, held_start, en, ERR_NONE, 1'b0, 1'b0};
          n               = 2'd1;
          held_valid_next = 1'b0;
        end
        if (mode == MODE_DQ || mode == MODE_SQ) begin
          kind  = KIND_STRING;
          nmode = (b == ((mode == MODE_DQ) ? CH_DQ : CH_SQ)) ? MODE_IDLE : mode;
        end else if (mode == MODE_UNQ && is_run_byte(b)) begin
          kind  = KIND_STRING;
          nmode = MODE_UNQ;
        end else if (is_blank(b)) begin
          kind = KIND_BLANK;
        end else if (b == CH_CR) begin
          kind  = KIND_CRLF;
          st    = 1'b1;
          nmode = MODE_CR;
        end else if (b == CH_COLON) begin
          kind = KIND_COLON;
          st   = 1'b1;
        end else if (b == CH_COMMA) begin
          kind = KIND_COMMA;
          st   = 1'b1;
        end else if (b == CH_DQ) begin
          kind  = KIND_STRING;
          st    = 1'b1;
          nmode = MODE_DQ;
        end else if (b == CH_SQ) begin
          kind  = KIND_STRING;
          st    = 1'b1;
          nmode = MODE_SQ;
        end else if (is_run_byte(b)) begin
          kind  = KIND_STRING;
          st    = 1'b1;
          nmode = MODE_UNQ;
        end else begin
          ok = 1'b0;
        end
        if (!ok || (eot && nmode == MODE_CR)) begin
          res[n[0]]       = '{b, KIND_BLANK, 1'b0, 1'b0, ERR_ILLEGAL, 1'b1, 1'b0};
          n               = n + 2'd1;
          held_valid_next = 1'b0;
          mode_next       = eot ? MODE_IDLE : MODE_DROP;
        end else if (eot) begin
          if (nmode == MODE_DQ || nmode == MODE_SQ) begin
            res[n[0]] = '{b, KIND_BLANK, 1'b0, 1'b0, ERR_UNTERM, 1'b1, 1'b0};
          end else begin
            res[n[0]] = '{b, kind, st,
                          (kind != KIND_BLANK && nmode == MODE_IDLE) || nmode == MODE_UNQ,
                          ERR_NONE, 1'b1, 1'b0};
          end
          n               = n + 2'd1;
          mode_next       = MODE_IDLE;
          held_valid_next = 1'b0;
        end else begin
          held_byte_next  = b;
          held_kind_next  = kind;
          held_start_next = st;
          held_valid_next = 1'b1;
          mode_next       = nmode;
        end
      end
    endcase
    if (n != 2'd0) begin
      res[n[0] ^ 1'b1].last_result = 1'b1;
    end
    res_cnt = n;
  end

endmodule

// ===== rtl/core/hht_outq.sv =====
module hht_outq import hht_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  res_t [1:0] wr_res,
  input  logic [1:0] wr_cnt,
  output logic       room,
  output res_t       rd_res,
  output logic       rd_valid,
  input  logic       rd_ready
);

  res_t [QDEPTH-1:0] entry;
  logic [QAW-1:0]    wr_ptr, rd_ptr;
  logic [QAW:0]      count, count_next;
  logic              pop;

  assign pop      = rd_valid && rd_ready;
  assign rd_valid = count != '0;
  assign rd_res   = entry[rd_ptr];
  assign room     = count <= (QAW+1)'(QDEPTH - 2);

  always_comb begin
    count_next = count + {1'b0, wr_cnt} - {{QAW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      entry[wr_ptr] <= wr_res[0];
    end
    if (wr_cnt == 2'd2) begin
      entry[wr_ptr + QAW'(1)] <= wr_res[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QAW'(wr_cnt);
      rd_ptr <= rd_ptr + QAW'(pop);
      count  <= count_next;
    end
  end

endmodule

// ===== tb/tb_http_header_tokenizer_top.sv =====
`timescale 1ns / 100ps

module tb_http_header_tokenizer_top;
  import hht_pkg::*;

  localparam int WD_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT = 300;
  localparam int DRAIN_AT = 400;
  localparam int TAIL_LEN = 120;

  typedef struct packed {
    logic [7:0] data;
    logic       eot;
    logic       drain;
  } req_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [7:0] m_tuser;
  logic       m_tlast;

  req_t       reqs[$];
  res_t       annot_q[$];
  bit   [7:0] txt[$];

  mode_t      lx_mode;
  logic [7:0] held_b;
  logic       held_v;
  logic [2:0] held_k;
  logic       held_s;

  int errs = 0;
  int n_in = 0;
  int n_out = 0;
  int n_texts = 0;
  int n_err_res = 0;
  int wd = 0;
  bit tail = 1'b0;
  bit drain_set = 1'b0;

  int   gap_left = 0;
  int   calm_left = 0;
  req_t nxt;
  logic nv;

  int   rgap = 0;
  int   rcalm = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  logic rdy;
  res_t exp_r;

  http_header_tokenizer_top dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit blank_byte(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0B || b == 8'h0C;
  endfunction

  function automatic bit unq_byte(input logic [7:0] b);
    return b > 8'h20 && b < 8'h7F && b != CH_COLON && b != CH_COMMA;
  endfunction

  function automatic res_t mk(input logic [7:0] b, input logic [2:0] k, input logic st,
                              input logic en, input logic [1:0] err, input logic done);
    res_t r;
    r.out_byte = b;
    r.token_kind = k;
    r.token_start = st;
    r.token_end = en;
    r.error_code = err;
    r.text_done = done;
    r.last_result = 1'b0;
    return r;
  endfunction

  // annotate one accepted request byte, queueing the results it releases
  function automatic void lex_byte(input logic [7:0] b, input logic eot);
    res_t       outs[2];
    res_t       r;
    int         n;
    logic [2:0] kind;
    logic       st;
    logic       en;
    logic       bad;
    mode_t      nmode;
    n = 0;
    bad = 1'b0;
    kind = KIND_BLANK;
    st = 1'b0;
    nmode = MODE_IDLE;
    if (lx_mode == MODE_DROP) begin
      if (eot) lx_mode = MODE_IDLE;
    end else if (lx_mode == MODE_CR) begin
      if (b != CH_LF) begin
        outs[0] = mk(held_b, KIND_BLANK, 1'b0, 1'b0, ERR_ILLEGAL, 1'b1);
        n = 1;
        held_v = 1'b0;
        lx_mode = eot ? MODE_IDLE : MODE_DROP;
      end else begin
        outs[0] = mk(held_b, KIND_CRLF, 1'b1, 1'b0, ERR_NONE, 1'b0);
        n = 1;
        if (eot) begin
          outs[1] = mk(b, KIND_CRLF, 1'b0, 1'b1, ERR_NONE, 1'b1);
          n = 2;
          held_v = 1'b0;
        end else begin
          held_b = b;
          held_k = KIND_CRLF;
          held_s = 1'b0;
          held_v = 1'b1;
        end
        lx_mode = MODE_IDLE;
      end
    end else begin
      if (held_v) begin
        if (lx_mode == MODE_UNQ) en = !unq_byte(b);
        else en = held_k != KIND_BLANK && lx_mode == MODE_IDLE;
        outs[n] = mk(held_b, held_k, held_s, en, ERR_NONE, 1'b0);
        n++;
        held_v = 1'b0;
      end
      if (lx_mode == MODE_DQ || lx_mode == MODE_SQ) begin
        kind = KIND_STRING;
        nmode = (b == (lx_mode == MODE_DQ ? CH_DQ : CH_SQ)) ? MODE_IDLE : lx_mode;
      end else if (lx_mode == MODE_UNQ && unq_byte(b)) begin
        kind = KIND_STRING;
        nmode = MODE_UNQ;
      end else if (blank_byte(b)) begin
        kind = KIND_BLANK;
      end else if (b == CH_CR) begin
        kind = KIND_CRLF; st = 1'b1; nmode = MODE_CR;
      end else if (b == CH_COLON) begin
        kind = KIND_COLON; st = 1'b1;
      end else if (b == CH_COMMA) begin
        kind = KIND_COMMA; st = 1'b1;
      end else if (b == CH_DQ) begin
        kind = KIND_STRING; st = 1'b1; nmode = MODE_DQ;
      end else if (b == CH_SQ) begin
        kind = KIND_STRING; st = 1'b1; nmode = MODE_SQ;
      end else if (unq_byte(b)) begin
        kind = KIND_STRING; st = 1'b1; nmode = MODE_UNQ;
      end else begin
        bad = 1'b1;
      end
      if (bad || (eot && nmode == MODE_CR)) begin
        outs[n] = mk(b, KIND_BLANK, 1'b0, 1'b0, ERR_ILLEGAL, 1'b1);
        n++;
        held_v = 1'b0;
        lx_mode = eot ? MODE_IDLE : MODE_DROP;
      end else if (eot) begin
        if (nmode == MODE_DQ || nmode == MODE_SQ) begin
          outs[n] = mk(b, KIND_BLANK, 1'b0, 1'b0, ERR_UNTERM, 1'b1);
        end else begin
          en = (kind != KIND_BLANK && nmode == MODE_IDLE) || nmode == MODE_UNQ;
          outs[n] = mk(b, kind, st, en, ERR_NONE, 1'b1);
        end
        n++;
        held_v = 1'b0;
        lx_mode = MODE_IDLE;
      end else begin
        held_b = b;
        held_k = kind;
        held_s = st;
        held_v = 1'b1;
        lx_mode = nmode;
      end
    end
    for (int i = 0; i < n; i++) begin
      r = outs[i];
      r.last_result = (i == n - 1);
      annot_q.insert(annot_q.size(), r);
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errs++;
    end
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) txt.insert(txt.size(), s[i]);
  endfunction

  function automatic void flush_text(input bit drain);
    req_t q;
    for (int i = 0; i < txt.size(); i++) begin
      q.data = txt[i];
      q.eot = (i == txt.size() - 1);
      q.drain = drain && (i == 0);
      reqs.insert(reqs.size(), q);
    end
    txt.delete();
  endfunction

  function automatic void add_run(input int len);
    bit [7:0] c;
    for (int i = 0; i < len; i++) begin
      do c = 8'($urandom_range(8'h21, 8'h7E)); while (c == CH_COLON || c == CH_COMMA);
      txt.insert(txt.size(), c);
    end
  endfunction

  function automatic void add_quoted(input bit [7:0] q);
    bit [7:0] c;
    int       len;
    len = $urandom_range(0, 4);
    txt.insert(txt.size(), q);
    for (int i = 0; i < len; i++) begin
      c = 8'($urandom_range(0, 255));
      if (c == q) c = 8'h00;
      txt.insert(txt.size(), c);
    end
    txt.insert(txt.size(), q);
  endfunction

  function automatic void gen_text();
    int ntok;
    int pos;
    ntok = $urandom_range(1, 8);
    repeat (ntok) begin
      case ($urandom_range(0, 9))
        0, 1: add_run($urandom_range(1, 6));
        2: add_quoted(CH_DQ);
        3: add_quoted(CH_SQ);
        4: begin
          case ($urandom_range(0, 3))
            0: txt.insert(txt.size(), 8'h20);
            1: txt.insert(txt.size(), 8'h09);
            2: txt.insert(txt.size(), 8'h0B);
            default: txt.insert(txt.size(), 8'h0C);
          endcase
        end
        5: begin
          txt.insert(txt.size(), CH_CR);
          txt.insert(txt.size(), CH_LF);
        end
        6: txt.insert(txt.size(), CH_COLON);
        7: txt.insert(txt.size(), CH_COMMA);
        default: begin
          // header line: name, colon, blank, value, crlf
          add_run($urandom_range(1, 5));
          txt.insert(txt.size(), CH_COLON);
          txt.insert(txt.size(), 8'h20);
          add_run($urandom_range(1, 5));
          txt.insert(txt.size(), CH_CR);
          txt.insert(txt.size(), CH_LF);
        end
      endcase
    end
    if ($urandom_range(0, 7) == 0) begin
      pos = $urandom_range(0, txt.size() - 1);
      case ($urandom_range(0, 3))
        0: txt[pos] = 8'($urandom_range(0, 255));
        1: begin
          txt.insert(txt.size(), $urandom_range(0, 1) ? CH_DQ : CH_SQ);
          if ($urandom_range(0, 1)) txt.insert(txt.size(), 8'($urandom_range(0, 255)));
        end
        2: txt[pos] = CH_CR;
        default: txt[pos] = CH_LF;
      endcase
    end
  endfunction

  // sender: one nonblocking write per signal per edge
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'h00;
      s_tlast <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        lex_byte(s_tdata, s_tlast);
        n_in++;
      end
      tail = reqs.size() < TAIL_LEN;
      if (!s_tvalid || s_tready) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (reqs.size() > 0) begin
          if (reqs[0].drain && annot_q.size() != 0) begin
            nv = 1'b0;
          end else if (!tail && calm_left == 0 && $urandom_range(0, 4) == 0) begin
            gap_left = $urandom_range(0, 9);
          end else begin
            nxt = reqs.pop_front();
            nv = 1'b1;
            s_tdata <= nxt.data;
            s_tlast <= nxt.eot;
            if (calm_left > 0) calm_left--;
            else if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(20, 60);
          end
        end
        s_tvalid <= nv;
      end
    end
  end

  // receiver and result check
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_out++;
        if (m_tlast) n_texts++;
        if (m_tuser[6:5] != ERR_NONE) n_err_res++;
        if (annot_q.size() == 0) begin
          $error("unexpected result: byte %0h user %0h", m_tdata, m_tuser);
          errs++;
        end else begin
          exp_r = annot_q.pop_front();
          check_field("out_byte", int'(exp_r.out_byte), int'(m_tdata));
          check_field("token_kind", int'(exp_r.token_kind), int'(m_tuser[2:0]));
          check_field("token_start", int'(exp_r.token_start), int'(m_tuser[3]));
          check_field("token_end", int'(exp_r.token_end), int'(m_tuser[4]));
          check_field("error_code", int'(exp_r.error_code), int'(m_tuser[6:5]));
          check_field("last_result", int'(exp_r.last_result), int'(m_tuser[7]));
          check_field("text_done", int'(exp_r.text_done), int'(m_tlast));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!hold_done && n_in >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        rdy = 1'b0;
      end else if (rgap > 0) begin
        rgap--;
        rdy = 1'b0;
      end else if (!tail && rcalm == 0 && $urandom_range(0, 5) == 0) begin
        rgap = $urandom_range(0, 9);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if (rcalm > 0) rcalm--;
        else if ($urandom_range(0, 24) == 0) rcalm = $urandom_range(20, 80);
      end
      m_tready <= rdy;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) wd <= 0;
      else wd <= wd + 1;
      if (wd >= WD_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    lx_mode = MODE_IDLE;
    held_b = 8'h00;
    held_v = 1'b0;
    held_k = KIND_BLANK;
    held_s = 1'b0;

    // every token kind, all four blanks, byte range extremes
    put_str("!: \"");
    txt.insert(txt.size(), 8'hFF);
    put_str("\",\t'z'");
    txt.insert(txt.size(), 8'h0B);
    txt.insert(txt.size(), 8'h0C);
    put_str("~");
    txt.insert(txt.size(), CH_CR);
    txt.insert(txt.size(), CH_LF);
    flush_text(1'b0);
    // illegal byte mid text, rest dropped
    put_str("a");
    txt.insert(txt.size(), 8'h00);
    put_str("bc");
    flush_text(1'b0);
    // lone lf
    txt.insert(txt.size(), CH_LF);
    flush_text(1'b0);
    // cr without lf
    txt.insert(txt.size(), CH_CR);
    put_str("x");
    flush_text(1'b0);
    // open quotes at end of text
    put_str("\"a");
    flush_text(1'b0);
    put_str("'");
    flush_text(1'b0);
    // cr as the final byte
    txt.insert(txt.size(), CH_CR);
    flush_text(1'b0);

    while (reqs.size() < 780) begin
      gen_text();
      if (!drain_set && reqs.size() >= DRAIN_AT) begin
        drain_set = 1'b1;
        flush_text(1'b1);
      end else begin
        flush_text(1'b0);
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (reqs.size() != 0 || s_tvalid || annot_q.size() != 0);
    repeat (20) @(posedge clk);
    if (annot_q.size() != 0) begin
      $error("%0d results never arrived", annot_q.size());
      errs++;
    end
    $display("%0d request bytes in, %0d annotated bytes out", n_in, n_out);
    $display("%0d texts closed, %0d of them by an error", n_texts, n_err_res);
    if (errs == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
